>>> rtl/core/tdtd_pkg.sv
// shared types, codes and reset values for the touch double tap detector
package tdtd_pkg;

    // gesture kinds carried on the input tuser
    typedef enum logic [1:0] {
        OP_PRESS   = 2'd0,
        OP_SWIPE   = 2'd1,
        OP_RELEASE = 2'd2,
        OP_OTHER   = 2'd3
    } op_t;

    // result codes
    typedef enum logic [2:0] {
        OUT_IGNORED   = 3'd0,
        OUT_PRESS     = 3'd1,
        OUT_SWIPE     = 3'd2,
        OUT_REJECTED  = 3'd3,
        OUT_GAP_SHORT = 3'd4,
        OUT_ARMED     = 3'd5,
        OUT_WAKE      = 3'd6
    } outcome_t;

    // configuration register indexes
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] CFG_TAP_MIN_HOLD  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TAP_MAX_HOLD  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_WAKE_COOLDOWN = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAP_MIN       = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAP_MAX       = 3'd4;

    // configuration reset values
    localparam logic [CFG_DATA_W-1:0] TAP_MIN_HOLD_RST  = 16'd30;
    localparam logic [CFG_DATA_W-1:0] TAP_MAX_HOLD_RST  = 16'd400;
    localparam logic [CFG_DATA_W-1:0] WAKE_COOLDOWN_RST = 16'd2000;
    localparam logic [CFG_DATA_W-1:0] GAP_MIN_RST       = 16'd80;
    localparam logic [CFG_DATA_W-1:0] GAP_MAX_RST       = 16'd500;

    localparam int unsigned STAMP_W = 32;
    localparam logic [STAMP_W-1:0] STAMP_NONE = '0;

    // payload widths on the stream ports
    localparam int unsigned S_DATA_W = 40;
    localparam int unsigned M_DATA_W = 8;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] tap_min_hold_ms;
        logic [CFG_DATA_W-1:0] tap_max_hold_ms;
        logic [CFG_DATA_W-1:0] wake_cooldown_ms;
        logic [CFG_DATA_W-1:0] gap_min_ms;
        logic [CFG_DATA_W-1:0] gap_max_ms;
    } cfg_t;

    typedef struct packed {
        logic               pressed;
        logic               swiped;
        logic [STAMP_W-1:0] press_stamp;
        logic [STAMP_W-1:0] first_tap_stamp;
        logic [STAMP_W-1:0] last_wake_stamp;
    } tap_state_t;

endpackage

>>> rtl/core/tdtd_decide.sv
// one event's decision: outcome code and next gesture state
module tdtd_decide (
    input  tdtd_pkg::cfg_t                  cfg,
    input  tdtd_pkg::tap_state_t            st,
    input  tdtd_pkg::op_t                   op,
    input  logic [tdtd_pkg::STAMP_W-1:0]    stamp_ms,
    input  logic                            busy_req,
    output tdtd_pkg::tap_state_t            st_next,
    output tdtd_pkg::outcome_t              outcome
);
    import tdtd_pkg::*;

    logic [STAMP_W-1:0] held;
    logic [STAMP_W-1:0] since_wake;
    logic [STAMP_W-1:0] gap;
    logic               hold_bad;
    logic               in_cooldown;
    logic               reject;
    logic               gap_short;
    logic               gap_long;

    // wrapping time differences and window checks
    always_comb
    begin
        held        = stamp_ms - st.press_stamp;
        since_wake  = stamp_ms - st.last_wake_stamp;
        gap         = stamp_ms - st.first_tap_stamp;
        hold_bad    = (held < {16'd0, cfg.tap_min_hold_ms})
                   || (held > {16'd0, cfg.tap_max_hold_ms});
        in_cooldown = (st.last_wake_stamp != STAMP_NONE)
                   && (since_wake < {16'd0, cfg.wake_cooldown_ms});
        reject      = !st.pressed || st.swiped || hold_bad || busy_req || in_cooldown;
        gap_short   = gap < {16'd0, cfg.gap_min_ms};
        gap_long    = gap > {16'd0, cfg.gap_max_ms};
    end

    // event handling
    always_comb
    begin
        st_next = st;
        outcome = OUT_IGNORED;
        case (op)
            OP_PRESS:
            begin
                st_next.pressed     = 1'b1;
                st_next.swiped      = 1'b0;
                st_next.press_stamp = stamp_ms;
                outcome             = OUT_PRESS;
            end
            OP_SWIPE:
            begin
                st_next.swiped = 1'b1;
                outcome        = OUT_SWIPE;
            end
            OP_RELEASE:
            begin
                st_next.pressed = 1'b0;
                st_next.swiped  = 1'b0;
                if (reject)
                begin
                    st_next.first_tap_stamp = STAMP_NONE;
                    outcome                 = OUT_REJECTED;
                end
                else if (st.first_tap_stamp != STAMP_NONE && !gap_short && !gap_long)
                begin
                    st_next.first_tap_stamp = STAMP_NONE;
                    st_next.last_wake_stamp = stamp_ms;
                    outcome                 = OUT_WAKE;
                end
                else if (st.first_tap_stamp != STAMP_NONE && gap_short)
                begin
                    outcome = OUT_GAP_SHORT;
                end
                else
                begin
                    st_next.first_tap_stamp = stamp_ms;
                    outcome                 = OUT_ARMED;
                end
            end
            default:
            begin
                outcome = OUT_IGNORED;
            end
        endcase
    end

endmodule

>>> rtl/core/touch_double_tap_detector.sv
// top level: stream ports, config registers, event pipeline and result register
// path: each event is held in the input register, then in the result register
// throughput: one event per cycle while the result port is not stalled; the decision is combinational
// the input stage accepts a new event while a finished result waits at the output, if the input register is empty
// reset: async active low; config returns to defaults, gesture state and stamps clear
// to zero (no press, no armed tap, no previous wake), both stages empty
module touch_double_tap_detector (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_we,
    input  logic [tdtd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [tdtd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // input events
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [tdtd_pkg::S_DATA_W-1:0]     s_axis_tdata,  // [31:0] stamp_ms, [32] busy_req
    input  logic [1:0]                        s_axis_tuser,  // [1:0] op
    // results
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [tdtd_pkg::M_DATA_W-1:0]     m_axis_tdata   // [0] wake, [3:1] outcome
);
    import tdtd_pkg::*;

    cfg_t               cfg_reg;
    tap_state_t         st_reg;
    tap_state_t         st_next;
    outcome_t           outcome;

    logic               in_valid_reg;
    op_t                in_op_reg;
    logic [STAMP_W-1:0] in_stamp_reg;
    logic               in_busy_reg;

    logic               out_valid_reg;
    logic               out_wake_reg;
    outcome_t           out_outcome_reg;

    logic               out_load;
    logic               s_accept;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tap_min_hold_ms  <= TAP_MIN_HOLD_RST;
            cfg_reg.tap_max_hold_ms  <= TAP_MAX_HOLD_RST;
            cfg_reg.wake_cooldown_ms <= WAKE_COOLDOWN_RST;
            cfg_reg.gap_min_ms       <= GAP_MIN_RST;
            cfg_reg.gap_max_ms       <= GAP_MAX_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_TAP_MIN_HOLD:  cfg_reg.tap_min_hold_ms  <= cfg_wdata;
                CFG_TAP_MAX_HOLD:  cfg_reg.tap_max_hold_ms  <= cfg_wdata;
                CFG_WAKE_COOLDOWN: cfg_reg.wake_cooldown_ms <= cfg_wdata;
                CFG_GAP_MIN:       cfg_reg.gap_min_ms       <= cfg_wdata;
                CFG_GAP_MAX:       cfg_reg.gap_max_ms       <= cfg_wdata;
                default:           cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    // handshake: result register frees up when empty or drained
    assign out_load      = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || out_load;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_op_reg    <= op_t'(s_axis_tuser);
            in_stamp_reg <= s_axis_tdata[STAMP_W-1:0];
            in_busy_reg  <= s_axis_tdata[STAMP_W];
        end
    end

    // decision logic
    tdtd_decide u_decide (
        .cfg      (cfg_reg),
        .st       (st_reg),
        .op       (in_op_reg),
        .stamp_ms (in_stamp_reg),
        .busy_req (in_busy_reg),
        .st_next  (st_next),
        .outcome  (outcome)
    );

    // gesture state, updated as each event moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else if (out_load)
        begin
            st_reg <= st_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_wake_reg    <= (outcome == OUT_WAKE);
            out_outcome_reg <= outcome;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_outcome_reg, out_wake_reg};

endmodule
